// ===== design/fr90_pkg.sv =====
// Shared types and constants for the frame rotator.
// No dependencies; imported by fr90_store and frame_rotate_90.
package fr90_pkg;

	localparam int PORT_PIX_W = 32;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int BPP_W      = 3;

	localparam logic [PORT_PIX_W-1:0] PIX24_MASK = 32'h00FF_FFFF;
	localparam logic [BPP_W-1:0]      BPP_32BIT  = 3'd4;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_BPP        = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

endpackage

// ===== design/frame_rotate_90.sv =====
// Frame rotator top level: 90 degree rotation through a frame store; needs fr90_pkg, fr90_store.
// A fetch request shows its result (done) in the cycle after acceptance.
// Throughput: one request per cycle, loads and fetches alike; loads use the
// store's write port, fetches its read port. busy stays low; results cannot be held off.
// Reset clears positions and sets width 1, height 1, 24-bit pixels; the
// store keeps no reset state and needs no clearing pass.
module frame_rotate_90 #(
	parameter int MAX_DIM    = 256,
	parameter int PIXEL_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [fr90_pkg::PORT_PIX_W-1:0]     pixel_in,
	output logic                                done,
	output logic [fr90_pkg::PORT_PIX_W-1:0]     pixel_out,
	output logic                                row_end,
	output logic [1:0]                          pad_bytes,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fr90_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fr90_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fr90_pkg::*;

	localparam int CW     = $clog2(MAX_DIM);
	localparam int DW     = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	logic          accept, load_req, fetch_req, cfg_wr;
	logic [DW-1:0] w_q, h_q, cfg_dim;
	logic          bpp4_q;
	logic [CW-1:0] load_col_q, load_row_q, out_col_q, out_row_q;
	logic          load_col_end, load_row_end, out_col_end, out_row_end;
	logic [DW-1:0] sx_full;
	logic [CW-1:0] sx;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [PIXEL_BITS-1:0] wdata, rdata;
	logic [PORT_PIX_W-1:0] in_mask, rd_ext;

	logic       valid_s1, row_end_s1, last_s1, bpp4_s1;
	logic [1:0] pad_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign load_req  = accept && (op_t'(opcode) == OP_LOAD);
	assign fetch_req = accept && (op_t'(opcode) == OP_FETCH);
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (int'(cfg_data) > MAX_DIM) begin
			cfg_dim = DW'(MAX_DIM);
		end else if (cfg_data == '0) begin
			cfg_dim = DW'(1);
		end else begin
			cfg_dim = DW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= DW'(1);
			h_q    <= DW'(1);
			bpp4_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  w_q    <= cfg_dim;
				REG_SRC_HEIGHT: h_q    <= cfg_dim;
				REG_BPP:        bpp4_q <= (cfg_data[BPP_W-1:0] == BPP_32BIT);
				default: ;
			endcase
		end
	end

	assign load_col_end = (DW'(load_col_q) == w_q - DW'(1));
	assign load_row_end = (DW'(load_row_q) == h_q - DW'(1));
	assign out_col_end  = (DW'(out_col_q) == h_q - DW'(1));
	assign out_row_end  = (DW'(out_row_q) == w_q - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q <= '0;
			load_row_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (cfg_wr && reg_idx_t'(cfg_index) != REG_NONE) begin
			load_col_q <= '0;
			load_row_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (load_req) begin
			if (load_col_end) begin
				load_col_q <= '0;
				load_row_q <= load_row_end ? '0 : load_row_q + CW'(1);
			end else begin
				load_col_q <= load_col_q + CW'(1);
			end
		end else if (fetch_req) begin
			if (out_col_end) begin
				out_col_q <= '0;
				out_row_q <= out_row_end ? '0 : out_row_q + CW'(1);
			end else begin
				out_col_q <= out_col_q + CW'(1);
			end
		end
	end

	// destination (dx, dy) reads source (W-1-dy, dx)
	assign sx_full = w_q - DW'(1) - DW'(out_row_q);
	assign sx      = sx_full[CW-1:0];
	assign raddr   = ADDR_W'(out_col_q) * ADDR_W'(MAX_DIM) + ADDR_W'(sx);
	assign waddr   = ADDR_W'(load_row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(load_col_q);
	assign in_mask = bpp4_q ? '1 : PIX24_MASK;
	assign wdata   = PIXEL_BITS'(pixel_in & in_mask);

	fr90_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (PIXEL_BITS)
	) u_store (
		.clk   (clk),
		.we    (load_req),
		.waddr (waddr),
		.wdata (wdata),
		.re    (fetch_req),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fetch_req;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_req) begin
			row_end_s1 <= out_col_end;
			last_s1    <= out_col_end && out_row_end;
			pad_s1     <= (out_col_end && !bpp4_q) ? h_q[1:0] : 2'd0;
			bpp4_s1    <= bpp4_q;
		end
	end

	assign rd_ext     = PORT_PIX_W'(rdata);
	assign done       = valid_s1;
	assign pixel_out  = bpp4_s1 ? rd_ext : (rd_ext & PIX24_MASK);
	assign row_end    = row_end_s1;
	assign pad_bytes  = pad_s1;
	assign frame_last = last_s1;

	a_done_follows_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fetch_req))
		else $error("result without a fetch request");

	a_last_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && frame_last) |-> row_end)
		else $error("frame end off a row end");

	a_pad_only_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !row_end) |-> (pad_bytes == 2'd0))
		else $error("pad count inside a row");

	a_cfg_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx_t'(cfg_index) != REG_NONE) |=>
			(load_col_q == '0 && load_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("positions not rewound by register write");

endmodule

// ===== design/fr90_store.sv =====
// Frame store: one write port, one read port, registered read data.
// Depends on fr90_pkg.
module fr90_store #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	import fr90_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== test/fr90_scoreboard.sv =====
// Scoreboard for the frame rotator bench: tracks store contents and frame
// positions, predicts each rotated pixel and checks results. Needs fr90_pkg.
package fr90_tb_pkg;
	import fr90_pkg::*;

	localparam int DIM_LIMIT = 256;

	typedef struct packed {
		logic [PORT_PIX_W-1:0] pixel;
		logic                  row_end;
		logic [1:0]            pad;
		logic                  last;
	} rot_pixel_t;

	class rotation_scoreboard;
		logic [PORT_PIX_W-1:0] store [DIM_LIMIT*DIM_LIMIT];
		bit                    filled [DIM_LIMIT*DIM_LIMIT];
		int unsigned           ld_col, ld_row, rd_col, rd_row;
		int unsigned           width_reg, height_reg;
		logic [BPP_W-1:0]      bpp_reg;
		rot_pixel_t            rotated_q[$];
		int unsigned           errors, loads, fetches;

		function new();
			width_reg = 1;
			height_reg = 1;
			bpp_reg = 3'd3;
			ld_col = 0;
			ld_row = 0;
			rd_col = 0;
			rd_row = 0;
			errors = 0;
			loads = 0;
			fetches = 0;
		endfunction

		function int unsigned clamp(int unsigned v);
			if (v == 0)
				return 1;
			if (v > DIM_LIMIT)
				return DIM_LIMIT;
			return v;
		endfunction

		function logic [PORT_PIX_W-1:0] pix_mask();
			return (bpp_reg == BPP_32BIT) ? '1 : PIX24_MASK;
		endfunction

		function int unsigned frame_size();
			return clamp(width_reg) * clamp(height_reg);
		endfunction

		// store word read by the next fetch
		function int unsigned src_addr();
			int unsigned w, h, dy, dx;
			w = clamp(width_reg);
			h = clamp(height_reg);
			dy = (rd_row < w) ? rd_row : w - 1;
			dx = (rd_col < h) ? rd_col : h - 1;
			return dx * DIM_LIMIT + (w - 1 - dy);
		endfunction

		function bit fetch_safe();
			return filled[src_addr()];
		endfunction

		function int unsigned pending();
			return rotated_q.size();
		endfunction

		function void note_config(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SRC_WIDTH: width_reg = 32'(val);
				REG_SRC_HEIGHT: height_reg = 32'(val);
				REG_BPP: bpp_reg = val[BPP_W-1:0];
				default: return;
			endcase
			ld_col = 0;
			ld_row = 0;
			rd_col = 0;
			rd_row = 0;
		endfunction

		function void note_request(op_t op, logic [PORT_PIX_W-1:0] pix);
			int unsigned w, h, dy, dx, a, bpp;
			rot_pixel_t e;
			w = clamp(width_reg);
			h = clamp(height_reg);
			bpp = (bpp_reg == BPP_32BIT) ? 4 : 3;
			if (op == OP_LOAD) begin
				a = ld_row * DIM_LIMIT + ld_col;
				store[a] = pix & pix_mask();
				filled[a] = 1'b1;
				loads++;
				if (ld_col + 1 >= w) begin
					ld_col = 0;
					ld_row = (ld_row + 1 >= h) ? 0 : ld_row + 1;
				end else begin
					ld_col++;
				end
				return;
			end
			dy = (rd_row < w) ? rd_row : w - 1;
			dx = (rd_col < h) ? rd_col : h - 1;
			a = src_addr();
			e.pixel = store[a] & pix_mask();
			e.row_end = (dx + 1 >= h);
			e.last = e.row_end && (dy + 1 >= w);
			e.pad = e.row_end ? 2'((4 - ((h * bpp) & 3)) & 3) : 2'd0;
			rotated_q.push_back(e);
			fetches++;
			if (e.row_end) begin
				rd_col = 0;
				rd_row = e.last ? 0 : dy + 1;
			end else begin
				rd_col = dx + 1;
			end
		endfunction

		function void check(rot_pixel_t got);
			rot_pixel_t e;
			bit bad;
			if (rotated_q.size() == 0) begin
				$error("result with no fetch waiting: pixel_out %h", got.pixel);
				errors++;
				return;
			end
			e = rotated_q.pop_front();
			bad = 1'b0;
			if (got.pixel !== e.pixel) begin
				$error("pixel_out: expected %h, got %h", e.pixel, got.pixel);
				bad = 1'b1;
			end
			if (got.row_end !== e.row_end) begin
				$error("row_end: expected %b, got %b", e.row_end, got.row_end);
				bad = 1'b1;
			end
			if (got.pad !== e.pad) begin
				$error("pad_bytes: expected %0d, got %0d", e.pad, got.pad);
				bad = 1'b1;
			end
			if (got.last !== e.last) begin
				$error("frame_last: expected %b, got %b", e.last, got.last);
				bad = 1'b1;
			end
			if (bad)
				errors++;
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level bench for frame_rotate_90: directed and random load/fetch
// traffic with register changes. Needs fr90_pkg, fr90_tb_pkg and the RTL.
module tb_top;
	import fr90_pkg::*;
	import fr90_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 250;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  opcode;
	logic [PORT_PIX_W-1:0] pixel_in;
	logic                  done;
	logic [PORT_PIX_W-1:0] pixel_out;
	logic                  row_end;
	logic [1:0]            pad_bytes;
	logic                  frame_last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rotation_scoreboard sb;
	int unsigned        cycles = 0;
	int unsigned        reg_writes = 0;
	int unsigned        settings = 0;
	bit                 burst = 1'b0;

	frame_rotate_90 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pixel_in   (pixel_in),
		.done       (done),
		.pixel_out  (pixel_out),
		.row_end    (row_end),
		.pad_bytes  (pad_bytes),
		.frame_last (frame_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(rot_pixel_t'{pixel_out, row_end, pad_bytes, frame_last});
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("frame_rotate_90: mismatch");
			$finish;
		end
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send(op_t op, logic [PORT_PIX_W-1:0] pix);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		pixel_in <= pix;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(op, pix);
	endtask

	// hold off requests until every fetch has returned, plus the result latency
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
			logic [CFG_DATA_W-1:0] bpp);
		drain();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SRC_WIDTH, w);
			write_reg(REG_SRC_HEIGHT, h);
			write_reg(REG_BPP, bpp);
		end else begin
			write_reg(REG_BPP, bpp);
			write_reg(REG_SRC_HEIGHT, h);
			write_reg(REG_SRC_WIDTH, w);
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, CFG_DATA_W'($urandom));
		settings++;
	endtask

	task automatic load_frame();
		repeat (sb.frame_size()) send(OP_LOAD, $urandom);
	endtask

	task automatic fetch_frame();
		repeat (sb.frame_size()) send(OP_FETCH, $urandom);
	endtask

	initial begin
		int unsigned                base;
		int unsigned                kind;
		logic [CFG_DATA_W-1:0]      w, h, bpp;
		logic [PORT_PIX_W-1:0]      corner [6];

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOAD;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: 1x1, 24-bit, upper byte dropped
		send(OP_LOAD, '1);
		send(OP_FETCH, '0);

		// 32-bit 3x2 frame, fetched eight times, past the frame end, to cover the wrap
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
		configure(9'd3, 9'd2, 9'd4);
		foreach (corner[i])
			send(OP_LOAD, corner[i]);
		repeat (8) send(OP_FETCH, '0);

		// zero width acts as one, pixel size 7 acts as 24-bit;
		// an unused register index leaves the positions alone
		configure(9'd0, 9'd3, 9'd7);
		send(OP_LOAD, 32'hFF12_3456);
		send(OP_LOAD, 32'h00AB_CDEF);
		drain();
		write_reg(REG_NONE, '1);
		send(OP_LOAD, 32'h7F00_00FF);
		repeat (3) send(OP_FETCH, '0);

		configure(9'd1, 9'd2, 9'd0);
		load_frame();
		fetch_frame();

		// widest frame, over-range width clamps; first rotated rows read the far columns
		configure(9'd511, 9'd1, 9'd3);
		load_frame();
		repeat (8) send(OP_FETCH, '0);

		base = sb.loads + sb.fetches;
		while (sb.loads + sb.fetches - base < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			w = CFG_DATA_W'($urandom_range(1, 8));
			h = CFG_DATA_W'($urandom_range(1, 8));
			if (kind == 0)
				w = CFG_DATA_W'($urandom_range(0, 20));
			else if (kind == 1)
				h = CFG_DATA_W'($urandom_range(0, 20));
			kind = $urandom_range(0, 9);
			if (kind < 4)
				bpp = 9'd3;
			else if (kind < 8)
				bpp = 9'd4;
			else
				bpp = CFG_DATA_W'($urandom_range(0, 7));
			configure(w, h, bpp);
			burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) begin
				load_frame();
				if ($urandom_range(0, 4) == 0)
					drain();
				repeat ($urandom_range(1, 2)) fetch_frame();
			end else begin
				repeat ($urandom_range(8, 30)) begin
					if ($urandom_range(0, 1) && sb.fetch_safe())
						send(OP_FETCH, $urandom);
					else
						send(OP_LOAD, $urandom);
				end
			end
			burst = 1'b0;
		end

		drain();
		$display("covered %0d loads and %0d fetches over %0d frame setups",
			sb.loads, sb.fetches, settings);
		$display("with %0d register writes, sizes 1x1 up to a clamped 256x1, 24/32-bit",
			reg_writes);
		if (sb.errors == 0)
			$display("frame_rotate_90: match");
		else
			$display("frame_rotate_90: mismatch");
		$finish;
	end

endmodule
